FILE: hw/rtl/assert_macros.svh
// Assertion macros for the top-level RTL file of the stick-to-servo mapper.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/scsm_pkg.sv
// Package for the stick-to-servo mapper: register map, reset values, flag type.
// No dependencies; imported by every module of the block.
package scsm_pkg;

    localparam int ADDR_BITS  = 5;
    localparam int PDATA_BITS = 32;

    localparam logic [ADDR_BITS-3:0] REG_ADC_CENTER    = 3'd0;
    localparam logic [ADDR_BITS-3:0] REG_ADC_LOWEST    = 3'd1;
    localparam logic [ADDR_BITS-3:0] REG_ADC_HIGHEST   = 3'd2;
    localparam logic [ADDR_BITS-3:0] REG_DEAD_BAND     = 3'd3;
    localparam logic [ADDR_BITS-3:0] REG_PULSE_CENTER  = 3'd4;
    localparam logic [ADDR_BITS-3:0] REG_PULSE_LOWEST  = 3'd5;
    localparam logic [ADDR_BITS-3:0] REG_PULSE_HIGHEST = 3'd6;
    localparam logic [ADDR_BITS-3:0] REG_REVERSE_DIR   = 3'd7;

    localparam logic [31:0] RST_ADC_CENTER    = 32'd2048;
    localparam logic [31:0] RST_ADC_LOWEST    = 32'd0;
    localparam logic [31:0] RST_ADC_HIGHEST   = 32'd4095;
    localparam logic [31:0] RST_DEAD_BAND     = 32'd0;
    localparam logic [31:0] RST_PULSE_CENTER  = 32'd1500;
    localparam logic [31:0] RST_PULSE_LOWEST  = 32'd1000;
    localparam logic [31:0] RST_PULSE_HIGHEST = 32'd2000;

    // Per-beat routing flags carried down the pipe.
    typedef struct packed {
        logic dz;     // inside dead band: centre, no clamp
        logic curve;  // span usable: apply quadratic term
        logic neg;    // pulse span negative: subtract quotient
    } scsm_flags_t;

endpackage

FILE: hw/rtl/scsm_front.sv
// First pipe stage: offset, direction, dead band and span selection.
// Depends on scsm_pkg.
module scsm_front #(
    parameter int SAMPLE_BITS = 12,
    parameter int PULSE_BITS  = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ld,
    input  logic                      vin,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic [SAMPLE_BITS-1:0]    adc_center,
    input  logic [SAMPLE_BITS-1:0]    adc_lowest,
    input  logic [SAMPLE_BITS-1:0]    adc_highest,
    input  logic [SAMPLE_BITS-1:0]    dead_band,
    input  logic [PULSE_BITS-1:0]     pulse_center,
    input  logic [PULSE_BITS-1:0]     pulse_lowest,
    input  logic [PULSE_BITS-1:0]     pulse_highest,
    input  logic                      reverse_dir,
    output logic                      vout,
    output logic [SAMPLE_BITS-1:0]    mag,
    output logic [SAMPLE_BITS-1:0]    span,
    output logic [PULSE_BITS-1:0]     pabs,
    output scsm_pkg::scsm_flags_t     flags
);
    import scsm_pkg::*;

    logic                   v_reg, v_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [PULSE_BITS-1:0]  pabs_reg, pabs_next;
    scsm_flags_t            flags_reg, flags_next;

    logic [SAMPLE_BITS:0]   diff, diff_neg;
    logic                   pos;
    logic [PULSE_BITS:0]    pspan, pspan_neg;

    always_comb
    begin
        diff     = {1'b0, sample} - {1'b0, adc_center};
        diff_neg = ~diff + 1'b1;
        // reversal flips the side; a zero offset always goes the negative way
        pos      = reverse_dir ? diff[SAMPLE_BITS] : (!diff[SAMPLE_BITS] && (diff != '0));
        mag_next = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

        if (pos)
        begin
            span_next        = adc_highest - adc_center;
            flags_next.curve = adc_highest > adc_center;
            pspan            = {1'b0, pulse_highest} - {1'b0, pulse_center};
        end
        else
        begin
            span_next        = adc_center - adc_lowest;
            flags_next.curve = adc_lowest < adc_center;
            pspan            = {1'b0, pulse_lowest} - {1'b0, pulse_center};
        end
        pspan_neg      = ~pspan + 1'b1;
        flags_next.neg = pspan[PULSE_BITS];
        pabs_next      = pspan[PULSE_BITS] ? pspan_neg[PULSE_BITS-1:0] : pspan[PULSE_BITS-1:0];
        flags_next.dz  = mag_next < dead_band;
        v_next         = ld ? vin : v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            mag_reg   <= mag_next;
            span_reg  <= span_next;
            pabs_reg  <= pabs_next;
            flags_reg <= flags_next;
        end
    end

    assign vout  = v_reg;
    assign mag   = mag_reg;
    assign span  = span_reg;
    assign pabs  = pabs_reg;
    assign flags = flags_reg;

endmodule

FILE: hw/rtl/scsm_mult.sv
// Two multiplier stages: squares of offset and span, then offset^2 * pulse span.
// Depends on scsm_pkg.
module scsm_mult #(
    parameter int SAMPLE_BITS = 12,
    parameter int PULSE_BITS  = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [1:0]                            ld,
    input  logic                                  vin,
    input  logic [SAMPLE_BITS-1:0]                mag,
    input  logic [SAMPLE_BITS-1:0]                span,
    input  logic [PULSE_BITS-1:0]                 pabs,
    input  scsm_pkg::scsm_flags_t                 flags_in,
    output logic [1:0]                            vout,
    output logic [2*SAMPLE_BITS+PULSE_BITS-1:0]   num,
    output logic [2*SAMPLE_BITS-1:0]              den,
    output scsm_pkg::scsm_flags_t                 flags_out
);
    import scsm_pkg::*;

    localparam int DW = 2 * SAMPLE_BITS;
    localparam int NW = DW + PULSE_BITS;

    logic [1:0]            v_reg, v_next;
    logic [DW-1:0]         osq_reg, osq_next;
    logic [DW-1:0]         dsq_reg, dsq_next;
    logic [PULSE_BITS-1:0] pabs_reg;
    scsm_flags_t           fa_reg, fb_reg;
    logic [NW-1:0]         num_reg, num_next;
    logic [DW-1:0]         den_reg;

    always_comb
    begin
        osq_next = DW'(mag) * DW'(mag);
        dsq_next = DW'(span) * DW'(span);
        num_next = NW'(osq_reg) * NW'(pabs_reg);
        v_next[0] = ld[0] ? vin      : v_reg[0];
        v_next[1] = ld[1] ? v_reg[0] : v_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            osq_reg  <= osq_next;
            dsq_reg  <= dsq_next;
            pabs_reg <= pabs;
            fa_reg   <= flags_in;
        end
        if (ld[1])
        begin
            num_reg <= num_next;
            den_reg <= dsq_reg;
            fb_reg  <= fa_reg;
        end
    end

    assign vout      = v_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign flags_out = fb_reg;

endmodule

FILE: hw/rtl/scsm_div_stage.sv
// One restoring-division stage: decides one quotient bit, or the overflow
// flag in the topmost stage. Depends on scsm_pkg.
module scsm_div_stage #(
    parameter int SAMPLE_BITS = 12,
    parameter int PULSE_BITS  = 12,
    parameter int BIT         = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ld,
    input  logic                                  vin,
    input  logic [2*SAMPLE_BITS+PULSE_BITS-1:0]   rem_in,
    input  logic [2*SAMPLE_BITS-1:0]              den_in,
    input  logic [PULSE_BITS:0]                   q_in,
    input  logic                                  sat_in,
    input  scsm_pkg::scsm_flags_t                 flags_in,
    output logic                                  vout,
    output logic [2*SAMPLE_BITS+PULSE_BITS-1:0]   rem_out,
    output logic [2*SAMPLE_BITS-1:0]              den_out,
    output logic [PULSE_BITS:0]                   q_out,
    output logic                                  sat_out,
    output scsm_pkg::scsm_flags_t                 flags_out
);
    import scsm_pkg::*;

    localparam int DW = 2 * SAMPLE_BITS;
    localparam int NW = DW + PULSE_BITS;
    localparam int QW = PULSE_BITS + 1;

    logic              v_reg, v_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     den_reg;
    logic [QW-1:0]     q_reg, q_next;
    logic              sat_reg, sat_next;
    scsm_flags_t       flags_reg;
    logic [NW:0]       den_sh;
    logic              ge;

    always_comb
    begin
        den_sh = {{QW{1'b0}}, den_in} << BIT;
        ge     = {1'b0, rem_in} >= den_sh;
        v_next = ld ? vin : v_reg;
    end

    generate
        if (BIT > PULSE_BITS)
        begin : g_ovf
            // quotient would not fit: result saturates, clamp decides
            always_comb
            begin
                rem_next = rem_in;
                q_next   = q_in;
                sat_next = sat_in | ge;
            end
        end
        else
        begin : g_bit
            always_comb
            begin
                rem_next = ge ? rem_in - den_sh[NW-1:0] : rem_in;
                q_next   = q_in;
                q_next[BIT] = ge;
                sat_next = sat_in;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            rem_reg   <= rem_next;
            den_reg   <= den_in;
            q_reg     <= q_next;
            sat_reg   <= sat_next;
            flags_reg <= flags_in;
        end
    end

    assign vout      = v_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign q_out     = q_reg;
    assign sat_out   = sat_reg;
    assign flags_out = flags_reg;

endmodule

FILE: hw/rtl/scsm_out.sv
// Output stage: signs the quotient, adds the centre pulse, clamps, holds the beat.
// Depends on scsm_pkg.
module scsm_out #(
    parameter int PULSE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ld,
    input  logic                   vin,
    input  logic [PULSE_BITS:0]    q,
    input  logic                   sat,
    input  scsm_pkg::scsm_flags_t  flags,
    input  logic [PULSE_BITS-1:0]  pulse_center,
    input  logic [PULSE_BITS-1:0]  pulse_lowest,
    input  logic [PULSE_BITS-1:0]  pulse_highest,
    output logic                   vout,
    output logic [PULSE_BITS-1:0]  pulse_width
);
    import scsm_pkg::*;

    localparam int QW = PULSE_BITS + 1;
    localparam int VW = PULSE_BITS + 3;

    logic                  v_reg, v_next;
    logic [PULSE_BITS-1:0] pw_reg, pw_next;
    logic [QW-1:0]         qmag;
    logic [VW-1:0]         qs, val;

    always_comb
    begin
        qmag = sat ? '1 : q;
        qs   = flags.neg ? VW'(0) - {2'b00, qmag} : {2'b00, qmag};
        val  = {3'b000, pulse_center} + (flags.curve ? qs : VW'(0));
        if (flags.dz)
        begin
            pw_next = pulse_center;
        end
        else if ($signed(val) > $signed({3'b000, pulse_highest}))
        begin
            pw_next = pulse_highest;
        end
        else if ($signed(val) < $signed({3'b000, pulse_lowest}))
        begin
            pw_next = pulse_lowest;
        end
        else
        begin
            pw_next = val[PULSE_BITS-1:0];
        end
        v_next = ld ? vin : v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            pw_reg <= pw_next;
        end
    end

    assign vout        = v_reg;
    assign pulse_width = pw_reg;

endmodule

FILE: hw/rtl/stick_to_servo_curve_mapper_top.sv
// Stick-to-servo curve mapper: dead band plus quadratic expo, fully pipelined.
// Depends on scsm_pkg, scsm_front, scsm_mult, scsm_div_stage, scsm_out.
//
// Input channel: in_valid / in_ready with one ADC reading, sample.
// Output channel: out_valid / out_ready with one pulse width in us,
//   pulse_width. Exactly one output beat per input beat, in order.
// Configuration: APB-style port, register i at byte address 4*i; pready is
//   tied high, writes land on the access cycle. Reconfigure only while idle.
// Pipe: front stage (offset, dead band, spans), two multiplier stages,
//   PULSE_BITS+2 restoring-division stages (one overflow check, then one
//   quotient bit each), and a clamp stage that is the output register.
// Each beat passes the front, multiplier, division and clamp stages in turn.
// Throughput: one beat per cycle while out_ready keeps the pipe moving; the
//   division chain sets the depth.
// Each stage loads when empty or when the stage after it moves, so bubbles
//   close up and in_ready stays high while any stage is free. With out_ready
//   low the pipe fills and then holds every beat; nothing dropped or repeated.
// Reset (rst_n low, asynchronous) clears all stage valids and loads the
//   registers with their defaults; payload registers are not reset.
module stick_to_servo_curve_mapper_top #(
    parameter int SAMPLE_BITS = 12,
    parameter int PULSE_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scsm_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [scsm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [scsm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,
    // input beat
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              sample,
    // output beat
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [PULSE_BITS-1:0]               pulse_width
);
    import scsm_pkg::*;

    `include "assert_macros.svh"

    localparam int DW = 2 * SAMPLE_BITS;
    localparam int NW = DW + PULSE_BITS;
    localparam int QW = PULSE_BITS + 1;
    localparam int ND = PULSE_BITS + 2;   // division stages
    localparam int NS = ND + 4;           // all stages
    localparam int OS = NS - 1;           // output stage index

    localparam logic [SAMPLE_BITS-1:0] INIT_ADC_CENTER    = RST_ADC_CENTER[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] INIT_ADC_LOWEST    = RST_ADC_LOWEST[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] INIT_ADC_HIGHEST   = RST_ADC_HIGHEST[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] INIT_DEAD_BAND     = RST_DEAD_BAND[SAMPLE_BITS-1:0];
    localparam logic [PULSE_BITS-1:0]  INIT_PULSE_CENTER  = RST_PULSE_CENTER[PULSE_BITS-1:0];
    localparam logic [PULSE_BITS-1:0]  INIT_PULSE_LOWEST  = RST_PULSE_LOWEST[PULSE_BITS-1:0];
    localparam logic [PULSE_BITS-1:0]  INIT_PULSE_HIGHEST = RST_PULSE_HIGHEST[PULSE_BITS-1:0];

    // ---------------- configuration registers ----------------
    logic [SAMPLE_BITS-1:0] adc_center_reg, adc_center_next;
    logic [SAMPLE_BITS-1:0] adc_lowest_reg, adc_lowest_next;
    logic [SAMPLE_BITS-1:0] adc_highest_reg, adc_highest_next;
    logic [SAMPLE_BITS-1:0] dead_band_reg, dead_band_next;
    logic [PULSE_BITS-1:0]  pulse_center_reg, pulse_center_next;
    logic [PULSE_BITS-1:0]  pulse_lowest_reg, pulse_lowest_next;
    logic [PULSE_BITS-1:0]  pulse_highest_reg, pulse_highest_next;
    logic                   reverse_dir_reg, reverse_dir_next;

    logic                   wr_en;
    logic [ADDR_BITS-3:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_BITS-1:2];   // byte lanes ignored

    always_comb
    begin
        adc_center_next    = adc_center_reg;
        adc_lowest_next    = adc_lowest_reg;
        adc_highest_next   = adc_highest_reg;
        dead_band_next     = dead_band_reg;
        pulse_center_next  = pulse_center_reg;
        pulse_lowest_next  = pulse_lowest_reg;
        pulse_highest_next = pulse_highest_reg;
        reverse_dir_next   = reverse_dir_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ADC_CENTER:    adc_center_next    = pwdata[SAMPLE_BITS-1:0];
                REG_ADC_LOWEST:    adc_lowest_next    = pwdata[SAMPLE_BITS-1:0];
                REG_ADC_HIGHEST:   adc_highest_next   = pwdata[SAMPLE_BITS-1:0];
                REG_DEAD_BAND:     dead_band_next     = pwdata[SAMPLE_BITS-1:0];
                REG_PULSE_CENTER:  pulse_center_next  = pwdata[PULSE_BITS-1:0];
                REG_PULSE_LOWEST:  pulse_lowest_next  = pwdata[PULSE_BITS-1:0];
                REG_PULSE_HIGHEST: pulse_highest_next = pwdata[PULSE_BITS-1:0];
                REG_REVERSE_DIR:   reverse_dir_next   = pwdata[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_center_reg    <= INIT_ADC_CENTER;
            adc_lowest_reg    <= INIT_ADC_LOWEST;
            adc_highest_reg   <= INIT_ADC_HIGHEST;
            dead_band_reg     <= INIT_DEAD_BAND;
            pulse_center_reg  <= INIT_PULSE_CENTER;
            pulse_lowest_reg  <= INIT_PULSE_LOWEST;
            pulse_highest_reg <= INIT_PULSE_HIGHEST;
            reverse_dir_reg   <= 1'b0;
        end
        else
        begin
            adc_center_reg    <= adc_center_next;
            adc_lowest_reg    <= adc_lowest_next;
            adc_highest_reg   <= adc_highest_next;
            dead_band_reg     <= dead_band_next;
            pulse_center_reg  <= pulse_center_next;
            pulse_lowest_reg  <= pulse_lowest_next;
            pulse_highest_reg <= pulse_highest_next;
            reverse_dir_reg   <= reverse_dir_next;
        end
    end

    // read mux, zero-extended
    always_comb
    begin
        case (reg_idx)
            REG_ADC_CENTER:    prdata = PDATA_BITS'(adc_center_reg);
            REG_ADC_LOWEST:    prdata = PDATA_BITS'(adc_lowest_reg);
            REG_ADC_HIGHEST:   prdata = PDATA_BITS'(adc_highest_reg);
            REG_DEAD_BAND:     prdata = PDATA_BITS'(dead_band_reg);
            REG_PULSE_CENTER:  prdata = PDATA_BITS'(pulse_center_reg);
            REG_PULSE_LOWEST:  prdata = PDATA_BITS'(pulse_lowest_reg);
            REG_PULSE_HIGHEST: prdata = PDATA_BITS'(pulse_highest_reg);
            REG_REVERSE_DIR:   prdata = PDATA_BITS'(reverse_dir_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- stage control ----------------
    // v: stage holds a beat; en: stage loads this cycle.
    logic [NS-1:0] v;
    logic [NS-1:0] en;

    assign en[OS] = !v[OS] || out_ready;
    generate
        for (genvar s = 0; s < OS; s++)
        begin : g_en
            assign en[s] = !v[s] || en[s+1];
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v[OS];

    // ---------------- front ----------------
    logic [SAMPLE_BITS-1:0] f_mag, f_span;
    logic [PULSE_BITS-1:0]  f_pabs;
    scsm_flags_t            f_flags;

    scsm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PULSE_BITS  (PULSE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .ld            (en[0]),
        .vin           (in_valid),
        .sample        (sample),
        .adc_center    (adc_center_reg),
        .adc_lowest    (adc_lowest_reg),
        .adc_highest   (adc_highest_reg),
        .dead_band     (dead_band_reg),
        .pulse_center  (pulse_center_reg),
        .pulse_lowest  (pulse_lowest_reg),
        .pulse_highest (pulse_highest_reg),
        .reverse_dir   (reverse_dir_reg),
        .vout          (v[0]),
        .mag           (f_mag),
        .span          (f_span),
        .pabs          (f_pabs),
        .flags         (f_flags)
    );

    // ---------------- multipliers ----------------
    logic [NW-1:0]  d_rem   [0:ND];
    logic [DW-1:0]  d_den   [0:ND];
    logic [QW-1:0]  d_q     [0:ND];
    logic           d_sat   [0:ND];
    scsm_flags_t    d_flags [0:ND];

    scsm_mult #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PULSE_BITS  (PULSE_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (en[2:1]),
        .vin       (v[0]),
        .mag       (f_mag),
        .span      (f_span),
        .pabs      (f_pabs),
        .flags_in  (f_flags),
        .vout      (v[2:1]),
        .num       (d_rem[0]),
        .den       (d_den[0]),
        .flags_out (d_flags[0])
    );

    assign d_q[0]   = '0;
    assign d_sat[0] = 1'b0;

    // ---------------- division chain, MSB first ----------------
    generate
        for (genvar k = 0; k < ND; k++)
        begin : g_div
            scsm_div_stage #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .PULSE_BITS  (PULSE_BITS),
                .BIT         (PULSE_BITS + 1 - k)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .ld        (en[3+k]),
                .vin       (v[2+k]),
                .rem_in    (d_rem[k]),
                .den_in    (d_den[k]),
                .q_in      (d_q[k]),
                .sat_in    (d_sat[k]),
                .flags_in  (d_flags[k]),
                .vout      (v[3+k]),
                .rem_out   (d_rem[k+1]),
                .den_out   (d_den[k+1]),
                .q_out     (d_q[k+1]),
                .sat_out   (d_sat[k+1]),
                .flags_out (d_flags[k+1])
            );
        end
    endgenerate

    // ---------------- clamp and output register ----------------
    scsm_out #(
        .PULSE_BITS (PULSE_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .ld            (en[OS]),
        .vin           (v[OS-1]),
        .q             (d_q[ND]),
        .sat           (d_sat[ND]),
        .flags         (d_flags[ND]),
        .pulse_center  (pulse_center_reg),
        .pulse_lowest  (pulse_lowest_reg),
        .pulse_highest (pulse_highest_reg),
        .vout          (v[OS]),
        .pulse_width   (pulse_width)
    );

    // ---------------- checks ----------------
    logic in_beat;
    logic out_beat;
    int   occ;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign occ      = $countones(v);

    // full pipe with a stalled receiver must refuse input
    `ASSERT_IMPLY(a_full_blocks, (&v) && !out_ready, !in_ready, "full pipe still ready")
    // a beat in with none out grows occupancy by exactly one
    `ASSERT_NEXT(a_occupancy, in_beat && !out_beat, occ == $past(occ) + 1, "beat lost or repeated")
    // a stalled full pipe keeps every beat
    `ASSERT_NEXT(a_hold_full, (&v) && !out_ready, &v, "beat dropped while stalled")

endmodule
